// ===== rtl/core/serial_keycode_receiver_matrix_top_defines.svh =====
// ----------------------------------------------------------------------------
// serial_keycode_receiver_matrix_top_defines
// Assertion macros shared by the keycode receiver modules.
// ----------------------------------------------------------------------------
`ifndef SERIAL_KEYCODE_RECEIVER_MATRIX_TOP_DEFINES_SVH
`define SERIAL_KEYCODE_RECEIVER_MATRIX_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication
`define SKRM_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication
`define SKRM_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SKRM_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg)
`define SKRM_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/skrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrm_pkg
// Shared types, codes and constants of the keycode receiver.
// ----------------------------------------------------------------------------
package skrm_pkg;

	localparam int FIFO_DEPTH_DEF = 16;
	localparam int ROW_COUNT      = 8;
	localparam int COL_COUNT      = 16;
	localparam int ROW_W          = 3;
	localparam int COL_W          = 4;
	localparam int KEY_W          = 7;
	localparam int CODE_W         = 8;
	localparam int TIME_W         = 16;
	localparam int CNT_W          = 4;
	localparam int CFG_ADDR_W     = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int IN_DATA_W      = 24;
	localparam int OUT_DATA_W     = 24;

	localparam logic [TIME_W-1:0] TIMEOUT_RST = 16'd100;
	localparam logic [KEY_W-1:0]  LOCK_A_RST  = 7'd69;
	localparam logic [KEY_W-1:0]  LOCK_B_RST  = 7'd58;
	localparam logic [CNT_W-1:0]  CNT_MAX     = 4'd15;

	// Item kinds carried on tuser
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_EDGE = 2'd0;
	localparam mode_t MODE_SCAN = 2'd1;
	localparam mode_t MODE_READ = 2'd2;

	// Configuration register indexes
	typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
	localparam cfg_addr_t CFG_TIMEOUT = 2'd0;
	localparam cfg_addr_t CFG_LOCK_A  = 2'd1;
	localparam cfg_addr_t CFG_LOCK_B  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLR,
		ST_DRAIN_RD,
		ST_DRAIN_AP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic edge_en;   // process a keyboard clock edge
		logic capture;   // latch item kind and row select, clear scan totals
		logic clr_locks; // clear both lock key bits
		logic rd_en;     // read FIFO head, advance read pointer
		logic apply_en;  // apply registered FIFO entry to the matrix
		logic load_out;  // load the result register
	} skrm_cmd_t;

	typedef struct packed {
		logic fifo_empty;
	} skrm_sts_t;

endpackage

// ===== rtl/core/skrm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrm_ctrl
// Sequencer for item intake, scan drain and result handoff.
// ----------------------------------------------------------------------------
`include "serial_keycode_receiver_matrix_top_defines.svh"

module skrm_ctrl
	import skrm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	output logic      s_tready,
	input  mode_t     mode,
	output logic      m_tvalid,
	input  logic      m_tready,
	input  skrm_sts_t sts,
	output skrm_cmd_t cmd
);

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Result valid flag: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					unique case (mode)
						MODE_EDGE: cmd.edge_en = 1'b1;
						MODE_SCAN: state_nxt = ST_CLR;
						MODE_READ: state_nxt = ST_EMIT;
						default:   state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_CLR: begin
				cmd.clr_locks = 1'b1;
				state_nxt     = ST_DRAIN_RD;
			end
			ST_DRAIN_RD: begin
				if (sts.fifo_empty) begin
					state_nxt = ST_EMIT;
				end else begin
					cmd.rd_en = 1'b1;
					state_nxt = ST_DRAIN_AP;
				end
			end
			ST_DRAIN_AP: begin
				cmd.apply_en = 1'b1;
				state_nxt    = ST_DRAIN_RD;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	`SKRM_ASSERT_IMP(a_load_into_free, clk, arst_n, cmd.load_out, !out_valid_q || m_tready, "result overwritten before taken")
	`SKRM_ASSERT_NXT(a_scan_starts, clk, arst_n, s_tvalid && s_tready && mode == MODE_SCAN, state_q == ST_CLR && !s_tready, "scan did not start clearing")
	`SKRM_ASSERT_NXT(a_read_then_apply, clk, arst_n, cmd.rd_en, cmd.apply_en, "FIFO entry read but not applied")

endmodule

// ===== rtl/core/skrm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skrm_dp
// Byte assembler, code FIFO, key matrix, config and result registers.
// ----------------------------------------------------------------------------
`include "serial_keycode_receiver_matrix_top_defines.svh"

module skrm_dp
	import skrm_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_addr_t             cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  data_bit,
	input  logic [TIME_W-1:0]     now_ms,
	input  logic [ROW_W-1:0]      row_sel,
	input  mode_t                 mode,
	input  skrm_cmd_t             cmd,
	output skrm_sts_t             sts,
	output logic [COL_COUNT-1:0]  row_bits,
	output logic [CNT_W-1:0]      codes_drained,
	output logic                  sync_lost_seen
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

	// Configuration
	logic [TIME_W-1:0] timeout_q;
	logic [KEY_W-1:0]  lock_a_q, lock_b_q;

	// Byte assembler
	logic [2:0]        bit_cnt_q;
	logic [CODE_W-1:0] acc_q;
	logic              restart_q;
	logic [TIME_W-1:0] start_q;

	// FIFO
	logic [CODE_W:0]   fifo_mem [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PTR_W-1:0]  wr_nxt, rd_nxt;
	logic [CODE_W:0]   rd_data_q;

	// Matrix and scan totals
	logic [ROW_COUNT-1:0][COL_COUNT-1:0] key_q;
	logic [ROW_COUNT-1:0][COL_COUNT-1:0] lock_mask;
	logic [CNT_W-1:0]  cnt_q;
	logic              lost_q;
	logic              is_read_q;
	logic [ROW_W-1:0]  row_sel_q;

	// Edge evaluation
	logic [TIME_W-1:0] elapsed;
	logic              timed_out;
	logic [2:0]        bc;
	logic [CODE_W-1:0] acc_in, acc_new;
	logic              rf;
	logic              byte_done;
	logic              push;

	// Drain evaluation
	logic [CODE_W-1:0] code;
	logic              key_set;

	assign sts.fifo_empty = (rd_ptr_q == wr_ptr_q);
	assign wr_nxt = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_nxt = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;

	// Config writes; unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
			lock_a_q  <= LOCK_A_RST;
			lock_b_q  <= LOCK_B_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_TIMEOUT: timeout_q <= cfg_wdata[TIME_W-1:0];
				CFG_LOCK_A:  lock_a_q  <= cfg_wdata[KEY_W-1:0];
				CFG_LOCK_B:  lock_b_q  <= cfg_wdata[KEY_W-1:0];
				default:     ;
			endcase
		end
	end

	// Restart the byte on timeout, then place the new bit
	always_comb begin
		elapsed   = now_ms - start_q;
		timed_out = (bit_cnt_q != 3'd0) && (elapsed > timeout_q);
		bc        = timed_out ? 3'd0 : bit_cnt_q;
		acc_in    = timed_out ? '0 : acc_q;
		rf        = timed_out | restart_q;
		acc_new   = acc_in | (CODE_W'(data_bit) << bc);
		byte_done = (bc == 3'd7);
		push      = cmd.edge_en && byte_done && (wr_nxt != rd_ptr_q);
	end

	// Assembler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			acc_q     <= '0;
			restart_q <= 1'b0;
			start_q   <= '0;
		end else if (cmd.edge_en) begin
			if (bc == 3'd0) begin
				start_q <= now_ms;
			end
			if (byte_done) begin
				bit_cnt_q <= '0;
				acc_q     <= '0;
				restart_q <= 1'b0;
			end else begin
				bit_cnt_q <= bc + 3'd1;
				acc_q     <= acc_new;
				restart_q <= rf;
			end
		end
	end

	// FIFO pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_nxt;
			end
			if (cmd.rd_en) begin
				rd_ptr_q <= rd_nxt;
			end
		end
	end

	// FIFO storage with registered read
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_mem[wr_ptr_q] <= {rf, acc_new};
		end
		if (cmd.rd_en) begin
			rd_data_q <= fifo_mem[rd_ptr_q];
		end
	end

	// Make, or lock key break, sets the bit; other breaks clear it
	assign code    = rd_data_q[CODE_W-1:0];
	assign key_set = !code[CODE_W-1] || (code == {1'b1, lock_a_q}) ||
		(code == {1'b1, lock_b_q});

	// Matrix bits of both lock keys
	always_comb begin
		lock_mask = '0;
		lock_mask[lock_a_q[KEY_W-1:COL_W]][lock_a_q[COL_W-1:0]] = 1'b1;
		lock_mask[lock_b_q[KEY_W-1:COL_W]][lock_b_q[COL_W-1:0]] = 1'b1;
	end

	// Key matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cmd.clr_locks) begin
			key_q <= key_q & ~lock_mask;
		end else if (cmd.apply_en) begin
			key_q[code[KEY_W-1:COL_W]][code[COL_W-1:0]] <= key_set;
		end
	end

	// Scan totals and item context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			lost_q    <= 1'b0;
			is_read_q <= 1'b0;
			row_sel_q <= '0;
		end else if (cmd.capture) begin
			cnt_q     <= '0;
			lost_q    <= 1'b0;
			is_read_q <= (mode == MODE_READ);
			row_sel_q <= row_sel;
		end else if (cmd.apply_en) begin
			if (cnt_q != CNT_MAX) begin
				cnt_q <= cnt_q + 1'b1;
			end
			lost_q <= lost_q | rd_data_q[CODE_W];
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (is_read_q) begin
				row_bits       <= key_q[row_sel_q];
				codes_drained  <= '0;
				sync_lost_seen <= 1'b0;
			end else begin
				row_bits       <= '0;
				codes_drained  <= cnt_q;
				sync_lost_seen <= lost_q;
			end
		end
	end

	`SKRM_ASSERT_IMP(a_rd_not_empty, clk, arst_n, cmd.rd_en, rd_ptr_q != wr_ptr_q, "FIFO read while empty")
	`SKRM_ASSERT_NXT(a_cnt_saturates, clk, arst_n, cmd.apply_en && cnt_q == CNT_MAX, cnt_q == CNT_MAX, "drain count wrapped")
	`SKRM_ASSERT_IMP(a_no_push_in_drain, clk, arst_n, cmd.rd_en || cmd.apply_en, !push, "FIFO push during drain")

endmodule

// ===== rtl/core/serial_keycode_receiver_matrix_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_keycode_receiver_matrix_top
// Keyboard scan code receiver with code FIFO and 8x16 key matrix.
// ----------------------------------------------------------------------------
// Clock edge items give no result; they can follow back to back.
// Read items go through the emit state to the result register; scan items first clear
// the lock keys, then do one FIFO read and one matrix update per drained code.
// One item is in work at a time; the next is taken once the sequencer is idle.
// arst_n clears the assembler, FIFO pointers, key matrix and config to defaults;
// FIFO contents are not cleared.
module serial_keycode_receiver_matrix_top
	import skrm_pkg::*;
#(
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // data_bit[0], now_ms[16:1], row_sel[19:17]
	input  logic [1:0]            s_tuser,  // mode[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // row_bits[15:0], codes_drained[19:16],
	                                        // sync_lost_seen[20]
);

	skrm_cmd_t            cmd;
	skrm_sts_t            sts;
	logic [COL_COUNT-1:0] row_bits;
	logic [CNT_W-1:0]     codes_drained;
	logic                 sync_lost_seen;

	assign m_tdata = {3'b000, sync_lost_seen, codes_drained, row_bits};

	skrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	skrm_dp #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.data_bit       (s_tdata[0]),
		.now_ms         (s_tdata[16:1]),
		.row_sel        (s_tdata[19:17]),
		.mode           (s_tuser),
		.cmd            (cmd),
		.sts            (sts),
		.row_bits       (row_bits),
		.codes_drained  (codes_drained),
		.sync_lost_seen (sync_lost_seen)
	);

endmodule

// ===== tb/sv/keycode_matrix_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keycode_matrix_checker
// Watches the configuration port and both item channels of the keycode
// receiver, keeps its own copy of the assembler, code FIFO and key matrix,
// and compares every result item against the oldest owed result.
// ----------------------------------------------------------------------------
module keycode_matrix_checker
	import skrm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // data_bit[0], now_ms[16:1], row_sel[19:17]
	input  logic [1:0]            s_tuser,  // mode[1:0]
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,  // row_bits[15:0], codes_drained[19:16],
	                                        // sync_lost_seen[20]
	output int                    fail_count,
	output int                    pending,
	output int                    result_count,
	output int                    pushed_count,
	output int                    dropped_count,
	output int                    restart_count
);

	localparam int PTR_W = $clog2(FIFO_DEPTH_DEF);

	typedef struct packed {
		logic [COL_COUNT-1:0] row_bits;
		logic [CNT_W-1:0]     codes_drained;
		logic                 sync_lost_seen;
	} keyscan_result_t;

	// configuration copy
	logic [TIME_W-1:0]    timeout_ms;
	logic [KEY_W-1:0]     lock_a;
	logic [KEY_W-1:0]     lock_b;

	// byte assembler
	logic [3:0]           rx_bits;
	logic [CODE_W-1:0]    rx_code;
	logic                 rx_lost;
	logic [TIME_W-1:0]    rx_start;

	// code FIFO, {lost, code} per entry, and key matrix
	logic [CODE_W:0]      code_store [FIFO_DEPTH_DEF];
	logic [PTR_W-1:0]     wr_ptr;
	logic [PTR_W-1:0]     rd_ptr;
	logic [COL_COUNT-1:0] key_rows [ROW_COUNT];

	keyscan_result_t      owed_results [$];

	int mismatches = 0;
	int outstanding = 0;
	int results_seen = 0;
	int codes_pushed = 0;
	int codes_dropped = 0;
	int byte_restarts = 0;

	assign fail_count    = mismatches;
	assign pending       = outstanding;
	assign result_count  = results_seen;
	assign pushed_count  = codes_pushed;
	assign dropped_count = codes_dropped;
	assign restart_count = byte_restarts;

	// Print one line per mismatch and count it
	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("MISMATCH at %0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	// One keyboard clock edge: restart a stale byte, shift in the bit, queue a full byte
	task automatic assemble_edge(input logic din, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] span;
		logic [PTR_W-1:0]  nxt;
		span = now - rx_start;
		if (rx_bits != 0 && span > timeout_ms) begin
			rx_lost = 1'b1;
			rx_code = '0;
			rx_bits = '0;
			byte_restarts++;
		end
		if (rx_bits == 0)
			rx_start = now;
		if (din)
			rx_code[rx_bits[2:0]] = 1'b1;
		rx_bits = rx_bits + 1'b1;
		if (rx_bits >= 8) begin
			nxt = wr_ptr + 1'b1;
			if (nxt != rd_ptr) begin
				code_store[wr_ptr] = {rx_lost, rx_code};
				wr_ptr = nxt;
				codes_pushed++;
			end else begin
				codes_dropped++;
			end
			rx_code = '0;
			rx_bits = '0;
			rx_lost = 1'b0;
		end
	endtask

	// Scan: drop both lock keys, then apply every queued code to the matrix
	task automatic drain_codes(output keyscan_result_t res);
		logic [CODE_W:0]   entry;
		logic [CODE_W-1:0] code;
		logic [CNT_W-1:0]  cnt;
		logic              lost;
		cnt  = '0;
		lost = 1'b0;
		key_rows[lock_a[6:4]][lock_a[3:0]] = 1'b0;
		key_rows[lock_b[6:4]][lock_b[3:0]] = 1'b0;
		while (rd_ptr != wr_ptr) begin
			entry  = code_store[rd_ptr];
			rd_ptr = rd_ptr + 1'b1;
			code   = entry[CODE_W-1:0];
			lost   = lost | entry[CODE_W];
			// make sets the key; a lock key's break also counts as make
			key_rows[code[6:4]][code[3:0]] = !code[7] || code == {1'b1, lock_a} ||
				code == {1'b1, lock_b};
			if (cnt != CNT_MAX)
				cnt = cnt + 1'b1;
		end
		res.row_bits       = '0;
		res.codes_drained  = cnt;
		res.sync_lost_seen = lost;
	endtask

	// Track config, check results, then predict the item accepted at this edge
	always @(posedge clk or negedge arst_n) begin
		keyscan_result_t got;
		keyscan_result_t want;
		if (!arst_n) begin
			timeout_ms = TIMEOUT_RST;
			lock_a     = LOCK_A_RST;
			lock_b     = LOCK_B_RST;
			rx_bits    = '0;
			rx_code    = '0;
			rx_lost    = 1'b0;
			rx_start   = '0;
			wr_ptr     = '0;
			rd_ptr     = '0;
			for (int r = 0; r < ROW_COUNT; r++)
				key_rows[r] = '0;
			owed_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					CFG_TIMEOUT: timeout_ms = cfg_wdata[TIME_W-1:0];
					CFG_LOCK_A:  lock_a = cfg_wdata[KEY_W-1:0];
					CFG_LOCK_B:  lock_b = cfg_wdata[KEY_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.row_bits       = m_tdata[15:0];
				got.codes_drained  = m_tdata[19:16];
				got.sync_lost_seen = m_tdata[20];
				if (owed_results.size() == 0) begin
					flag_mismatch("result item with none owed", 32'(m_tdata), 32'd0);
				end else begin
					want = owed_results.pop_front();
					if (got.row_bits !== want.row_bits)
						flag_mismatch("row_bits", 32'(got.row_bits), 32'(want.row_bits));
					if (got.codes_drained !== want.codes_drained)
						flag_mismatch("codes_drained", 32'(got.codes_drained),
							32'(want.codes_drained));
					if (got.sync_lost_seen !== want.sync_lost_seen)
						flag_mismatch("sync_lost_seen", 32'(got.sync_lost_seen),
							32'(want.sync_lost_seen));
				end
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					MODE_EDGE: assemble_edge(s_tdata[0], s_tdata[16:1]);
					MODE_SCAN: begin
						drain_codes(want);
						owed_results.push_back(want);
					end
					MODE_READ: begin
						want.row_bits       = key_rows[s_tdata[19:17]];
						want.codes_drained  = '0;
						want.sync_lost_seen = 1'b0;
						owed_results.push_back(want);
					end
					default: ;
				endcase
			end
		end
		outstanding = owed_results.size();
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives keyboard edge, scan and read items into the keycode receiver under
// several register settings, with random idling on both channels, a long
// result hold-off and FIFO overflow; the checker judges every result item.
// ----------------------------------------------------------------------------
module testbench;
	import skrm_pkg::*;

	localparam mode_t     MODE_SPARE  = 2'd3;
	localparam cfg_addr_t CFG_SPARE   = 2'd3;
	localparam int        LONG_HOLD   = 300;
	localparam int        DRAIN_GUARD = 40;
	localparam int        CFG_SETTLE  = 12;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;  // data_bit[0], now_ms[16:1], row_sel[19:17]
	logic [1:0]            s_tuser;  // mode[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;  // row_bits[15:0], codes_drained[19:16],
	                                 // sync_lost_seen[20]

	int fail_count;
	int pending;
	int result_count;
	int pushed_count;
	int dropped_count;
	int restart_count;

	logic [TIME_W-1:0] clock_ms;
	logic [KEY_W-1:0]  lock_a_cur;
	logic [KEY_W-1:0]  lock_b_cur;
	logic [KEY_W-1:0]  key_pool [8];
	int                items_sent = 0;
	int                hold_request = 0;
	bit                src_calm = 1'b0;
	bit                sink_calm = 1'b0;

	serial_keycode_receiver_matrix_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	keycode_matrix_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.fail_count    (fail_count),
		.pending       (pending),
		.result_count  (result_count),
		.pushed_count  (pushed_count),
		.dropped_count (dropped_count),
		.restart_count (restart_count)
	);

	// 100 MHz clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the run hangs
	initial begin
		#20_000_000;
		$display("FAIL serial_keycode_receiver_matrix_top");
		$finish;
	end

	// Result side: random stalls, calm stretches, and one long hold-off on request
	initial begin
		int stall_left;
		int r;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				sink_calm = !sink_calm;
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (sink_calm) begin
				m_tready <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					m_tready <= 1'b1;
				end else begin
					m_tready <= 1'b0;
					stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(14, 59);
				end
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (src_calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Time between keyboard edges: mostly tight, sometimes late, rarely anywhere
	function automatic logic [TIME_W-1:0] pick_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return '0;
		if (r < 90)
			return TIME_W'($urandom_range(1, 5));
		if (r < 97)
			return TIME_W'($urandom_range(6, 150));
		return TIME_W'($urandom);
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		if ($urandom_range(0, 7) == 0)
			return CODE_W'($urandom);
		return {1'($urandom), key_pool[$urandom_range(0, 7)]};
	endfunction

	// Offer one item after a random gap and hold it until accepted
	task automatic push_item(input mode_t kind, input logic din,
		input logic [TIME_W-1:0] now, input logic [ROW_W-1:0] sel);
		int gap;
		if ($urandom_range(0, 149) == 0)
			src_calm = !src_calm;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= IN_DATA_W'({sel, now, din});
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (kind != MODE_SPARE)
			items_sent++;
	endtask

	task automatic send_edge(input logic din, input logic [TIME_W-1:0] step);
		clock_ms = clock_ms + step;
		push_item(MODE_EDGE, din, clock_ms, ROW_W'($urandom));
	endtask

	// Byte LSB first: step before bit 0, step to bit 1, step between later bits
	task automatic send_byte(input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] first,
		input logic [TIME_W-1:0] second, input logic [TIME_W-1:0] rest);
		for (int i = 0; i < CODE_W; i++)
			send_edge(code[i], (i == 0) ? first : (i == 1) ? second : rest);
	endtask

	task automatic send_byte_random(input logic [CODE_W-1:0] code);
		for (int i = 0; i < CODE_W; i++)
			send_edge(code[i], pick_step());
	endtask

	task automatic push_scan();
		push_item(MODE_SCAN, 1'($urandom), TIME_W'($urandom), ROW_W'($urandom));
	endtask

	task automatic push_read(input logic [ROW_W-1:0] sel);
		push_item(MODE_READ, 1'($urandom), TIME_W'($urandom), sel);
	endtask

	// Stop offering, wait for every owed result, then let the block go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (CFG_SETTLE) @(posedge clk);
	endtask

	// Write all registers; junk in the unused upper data bits of the key registers
	task automatic program_regs(input logic [TIME_W-1:0] timeout, input logic [KEY_W-1:0] ka,
		input logic [KEY_W-1:0] kb, input bit spare);
		cfg_we    <= 1'b1;
		cfg_addr  <= CFG_TIMEOUT;
		cfg_wdata <= timeout;
		@(posedge clk);
		cfg_addr  <= CFG_LOCK_A;
		cfg_wdata <= {(CFG_DATA_W-KEY_W)'($urandom), ka};
		@(posedge clk);
		cfg_addr  <= CFG_LOCK_B;
		cfg_wdata <= {(CFG_DATA_W-KEY_W)'($urandom), kb};
		@(posedge clk);
		if (spare) begin
			cfg_addr  <= CFG_SPARE;
			cfg_wdata <= CFG_DATA_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		lock_a_cur = ka;
		lock_b_cur = kb;
	endtask

	// Mostly well-formed code bursts followed by a scan, mixed with broken bytes and noise
	task automatic run_random(input int n);
		int goal;
		int pick;
		int burst;
		goal = items_sent + n;
		key_pool[0] = lock_a_cur;
		key_pool[1] = lock_b_cur;
		for (int i = 2; i < 8; i++)
			key_pool[i] = KEY_W'($urandom);
		while (items_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				burst = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
				repeat (burst) send_byte_random(pick_code());
				push_scan();
				repeat ($urandom_range(0, 3)) push_read(ROW_W'($urandom));
			end else if (pick < 68) begin
				repeat ($urandom_range(1, 7)) send_edge(1'($urandom), pick_step());
			end else if (pick < 78) begin
				push_scan();
			end else if (pick < 93) begin
				push_read(ROW_W'($urandom));
			end else begin
				push_item(MODE_SPARE, 1'($urandom), TIME_W'($urandom), ROW_W'($urandom));
			end
		end
	endtask

	// Stimulus and verdict
	initial begin
		arst_n     = 1'b0;
		cfg_we    <= 1'b0;
		cfg_addr  <= CFG_TIMEOUT;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= MODE_EDGE;
		lock_a_cur = LOCK_A_RST;
		lock_b_cur = LOCK_B_RST;
		clock_ms   = 16'hFFFA;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scan with nothing queued, and an unused item kind
		push_scan();
		push_item(MODE_SPARE, 1'b1, 16'hFFFF, 3'd7);
		// make of key 0 while the millisecond counter wraps
		send_byte(8'h00, 16'd0, 16'd1, 16'd1);
		// lock key breaks count as make; second one lands exactly on the timeout
		send_byte({1'b1, LOCK_A_RST}, 16'd3, 16'd2, 16'd2);
		send_byte({1'b1, LOCK_B_RST}, 16'd1, TIMEOUT_RST, 16'd0);
		// stale partial byte restarts; the next code carries lost sync
		repeat (3) send_edge(1'b1, 16'd1);
		send_byte(8'h7F, 16'd250, 16'd0, 16'd0);
		send_byte(8'hFF, 16'd1, 16'd1, 16'd1);
		push_scan();
		push_read(3'd0);
		push_read(3'd3);
		push_read(3'd4);
		push_read(3'd7);
		// second scan drops the lock keys again
		push_scan();
		push_read(3'd4);

		// hold off results long enough for the block to stall its input
		settle();
		hold_request = LONG_HOLD;
		repeat (16) push_read(ROW_W'($urandom));
		settle();

		// random traffic under several register settings, extremes first
		run_random(120);
		settle();
		program_regs(16'd0, 7'd0, 7'd127, 1'b1);
		run_random(120);
		settle();
		program_regs(16'hFFFF, 7'd127, 7'd0, 1'b0);
		run_random(120);
		settle();
		program_regs(TIME_W'($urandom_range(1, 40)), KEY_W'($urandom), KEY_W'($urandom), 1'b1);
		run_random(170);
		settle();
		program_regs(TIME_W'($urandom), KEY_W'($urandom), KEY_W'($urandom), 1'b0);
		run_random(170);

		settle();
		repeat (DRAIN_GUARD) @(posedge clk);
		$display("Run covered %0d items over five register settings, %0d result items checked.",
			items_sent, result_count);
		$display("Codes queued %0d, lost to a full FIFO %0d, bytes restarted on timeout %0d.",
			pushed_count, dropped_count, restart_count);
		if (fail_count == 0 && pending == 0)
			$display("PASS serial_keycode_receiver_matrix_top");
		else
			$display("FAIL serial_keycode_receiver_matrix_top");
		$finish;
	end

endmodule
